@@ rtl/core/sga_pkg.sv @@
// Shared widths, status codes and sequencer states for the gravity accumulator.
package sga_pkg;

  localparam int MUL_A_W = 64;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W = 101;
  localparam int DIV_D_W = 64;
  localparam int ROOT_W  = 32;

  localparam logic [1:0] CODE_OK   = 2'd0;
  localparam logic [1:0] CODE_PN   = 2'd1;
  localparam logic [1:0] CODE_ZERO = 2'd2;
  localparam logic [1:0] CODE_SAT  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_RSQ,
    ST_POT,
    ST_AMUL,
    ST_ADIV,
    ST_DONE
  } state_t;

  function automatic logic [1:0] raise_code(input logic [1:0] old, input logic [1:0] code);
    return (code > old) ? code : old;
  endfunction

endpackage

@@ rtl/core/sga_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module sga_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [sga_pkg::MUL_A_W-1:0]  a,
  input  logic [sga_pkg::MUL_B_W-1:0]  b,
  output logic                         done,
  output logic [sga_pkg::MUL_P_W-1:0]  product
);
  import sga_pkg::*;

  logic [MUL_A_W-1:0]   a_q;
  logic [MUL_P_W-1:0]   prod;
  logic [4:0]           cnt;
  logic                 busy;
  logic [MUL_A_W:0]     sum;

  assign sum = {1'b0, prod[MUL_P_W-1:MUL_B_W]} + (prod[0] ? {1'b0, a_q} : '0);
  assign product = prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q  <= a;
      prod <= {{MUL_A_W{1'b0}}, b};
    end else if (busy) begin
      prod <= {sum, prod[MUL_B_W-1:1]};
    end
  end

endmodule

@@ rtl/core/sga_div.sv @@
// Restoring divider, one quotient bit per cycle, quotient clipped to all ones.
module sga_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [sga_pkg::DIV_N_W-1:0]  num,
  input  logic [sga_pkg::DIV_D_W-1:0]  den,
  output logic                         done,
  output logic [sga_pkg::DIV_D_W-1:0]  quotient
);
  import sga_pkg::*;

  logic [DIV_N_W-1:0] n_q;
  logic [DIV_D_W-1:0] d_q;
  logic [DIV_D_W-1:0] rem;
  logic [DIV_D_W-1:0] q;
  logic               ovf;
  logic [6:0]         cnt;
  logic               busy;
  logic [DIV_D_W:0]   trial;
  logic [DIV_D_W:0]   diff;
  logic               ge;

  assign trial = {rem, n_q[DIV_N_W-1]};
  assign ge    = trial >= {1'b0, d_q};
  assign diff  = trial - {1'b0, d_q};
  assign quotient = ovf ? '1 : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'(DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_q <= num;
      d_q <= den;
      rem <= '0;
      q   <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      rem <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      q   <= {q[DIV_D_W-2:0], ge};
      // any bit pushed out of the quotient means it does not fit
      ovf <= ovf | q[DIV_D_W-1];
      n_q <= {n_q[DIV_N_W-2:0], 1'b0};
    end
  end

endmodule

@@ rtl/core/sga_sqrt.sv @@
// Integer square root, two radicand bits and one root bit per cycle.
module sga_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [2*sga_pkg::ROOT_W-1:0]  radicand,
  output logic                          done,
  output logic [sga_pkg::ROOT_W-1:0]    root
);
  import sga_pkg::*;

  logic [2*ROOT_W-1:0] v_q;
  logic [ROOT_W+3:0]   rem;
  logic [ROOT_W+3:0]   rem_sh;
  logic [ROOT_W+3:0]   trial;
  logic [4:0]          cnt;
  logic                busy;
  logic                ge;

  assign rem_sh = {rem[ROOT_W+1:0], v_q[2*ROOT_W-1:2*ROOT_W-2]};
  assign trial  = {2'b00, root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_q  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rem  <= ge ? (rem_sh - trial) : rem_sh;
      root <= {root[ROOT_W-2:0], ge};
      v_q  <= {v_q[2*ROOT_W-3:0], 2'b00};
    end
  end

endmodule

@@ rtl/core/softened_gravity_accumulator_unit.sv @@
// Softened direct-summation gravity accumulator: sequencer, sums and stream ports.
//
// Input channel s_axis: one source body per transfer, with the target position,
// the source position and mass in tdata, the self flag in tuser and the end of
// the source list in tlast. Output channel m_axis: one transfer per tlast input,
// carrying the potential and acceleration sums in tdata and the status in tuser.
// softening_wr_en/softening_wr_data write the softening register (reset 3277).
//
// Items are handled one at a time; a self item goes straight to the final state.
// Any other item runs through a shared bit-serial multiplier, a bit-serial
// square root and a bit-serial divider: seven products, one root and four
// quotients in either mode, and the next transfer is taken only once the
// previous item is through; a skipped source (zero distance, violation)
// ends early. The divider dominates.
// Reset clears the sums, the status and the output valid flag.
// A finished result waits in the output register; a tlast item whose result
// finds that register still full holds in its last state until the receiver
// takes the earlier transfer.
module softened_gravity_accumulator_unit #(
  parameter int SUM_BITS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         softening_wr_en,
  input  logic [31:0]  softening_wr_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // target_x, target_y, target_z, source_x, source_y, source_z, source_mass
  input  logic [223:0] s_axis_tdata,
  // is_self
  input  logic         s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // potential, accel_x, accel_y, accel_z
  output logic [255:0] m_axis_tdata,
  // status
  output logic [1:0]   m_axis_tuser
);
  import sga_pkg::*;

  localparam logic [63:0] TERM_MAX = {{(65 - SUM_BITS){1'b0}}, {(SUM_BITS - 1){1'b1}}};

  state_t state, state_next;
  logic   pending, pending_next;

  logic signed [31:0]         softening;
  logic [31:0]                mag [3];
  logic [2:0]                 neg;
  logic [31:0]                mass;
  logic                       last_q;
  logic [1:0]                 idx;
  logic [65:0]                sumsq;
  logic [65:0]                sumsq_new;
  logic [63:0]                r2;
  logic [31:0]                r;
  logic [63:0]                p;
  logic [DIV_N_W-1:0]         num_a;
  logic signed [SUM_BITS-1:0] potential_sum;
  logic signed [SUM_BITS-1:0] accel_sum [3];
  logic [1:0]                 error_flags;
  logic [1:0]                 flags_next;

  logic                mul_start, mul_done;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [MUL_P_W-1:0]  mul_p;
  logic                div_start, div_done;
  logic [DIV_N_W-1:0]  div_num;
  logic [DIV_D_W-1:0]  div_den;
  logic [DIV_D_W-1:0]  div_q;
  logic                sqrt_start, sqrt_done;
  logic [ROOT_W-1:0]   sqrt_root;

  logic                eps_neg;
  logic [31:0]         eps_abs;
  logic [31:0]         half;
  logic [32:0]         shifted_r;
  logic                sq_last;
  logic                out_free;
  logic                emit;
  logic                accept;

  // saturating add path, shared by the potential and the three axes
  logic [63:0]                term_mag;
  logic                       term_clip;
  logic                       term_neg;
  logic signed [SUM_BITS:0]   term;
  logic signed [SUM_BITS:0]   acc_ext;
  logic signed [SUM_BITS:0]   acc_sum;
  logic signed [SUM_BITS-1:0] acc_sel;
  logic signed [SUM_BITS-1:0] acc_res;
  logic                       acc_sat;

  logic signed [32:0] d_in [3];

  sga_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .product(mul_p)
  );

  sga_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quotient(div_q)
  );

  sga_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .radicand(r2),
    .done(sqrt_done), .root(sqrt_root)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign emit          = (state == ST_DONE) && last_q && out_free;

  assign eps_neg   = softening[31];
  assign eps_abs   = 32'(32'd0 - softening);
  assign half      = 32'((33'({1'b0, eps_abs}) + 33'd1) >> 1);
  assign shifted_r = {1'b0, sqrt_root} - {1'b0, half};
  assign sumsq_new = sumsq + {2'b00, mul_p[63:0]};
  assign sq_last   = (idx == 2'd3) || ((idx == 2'd2) && eps_neg);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_in[i] = {s_axis_tdata[96+32*i+31], s_axis_tdata[96+32*i +: 32]}
              - {s_axis_tdata[32*i+31], s_axis_tdata[32*i +: 32]};
    end
  end

  // unit operand selection
  always_comb begin
    mul_a = {32'd0, r};
    mul_b = r;
    case (state)
      ST_SQ: begin
        case (idx)
          2'd0:    mul_b = mag[0];
          2'd1:    mul_b = mag[1];
          2'd2:    mul_b = mag[2];
          default: mul_b = softening[31:0];
        endcase
        mul_a = {32'd0, mul_b};
      end
      ST_AMUL: begin
        mul_a = p;
        mul_b = mag[idx];
      end
      default: begin
        mul_a = {32'd0, r};
        mul_b = r;
      end
    endcase
    if (state == ST_POT) begin
      div_num = {46'd0, mass, 23'd0};
      div_den = {32'd0, r};
    end else begin
      div_num = num_a;
      div_den = r2;
    end
  end

  always_comb begin
    term_clip = div_q > TERM_MAX;
    term_mag  = term_clip ? TERM_MAX : div_q;
    term_neg  = (state == ST_POT) ? 1'b1 : neg[idx];
    term      = term_neg ? -$signed({1'b0, term_mag[SUM_BITS-1:0]})
                         : $signed({1'b0, term_mag[SUM_BITS-1:0]});
    acc_sel   = (state == ST_POT) ? potential_sum : accel_sum[idx];
    acc_ext   = {acc_sel[SUM_BITS-1], acc_sel};
    acc_sum   = acc_ext + term;
    acc_sat   = acc_sum[SUM_BITS] != acc_sum[SUM_BITS-1];
    if (!acc_sat) begin
      acc_res = acc_sum[SUM_BITS-1:0];
    end else if (acc_sum[SUM_BITS]) begin
      acc_res = {1'b1, {(SUM_BITS - 1){1'b0}}};
    end else begin
      acc_res = {1'b0, {(SUM_BITS - 1){1'b1}}};
    end
  end

  // next state, unit launches and status merging
  always_comb begin
    state_next   = state;
    pending_next = pending;
    mul_start    = 1'b0;
    div_start    = 1'b0;
    sqrt_start   = 1'b0;
    flags_next   = error_flags;
    case (state)
      ST_IDLE: begin
        pending_next = 1'b0;
        if (accept) begin
          state_next = s_axis_tuser ? ST_DONE : ST_SQ;
        end
      end
      ST_SQ: begin
        mul_start    = !pending;
        pending_next = 1'b1;
        if (mul_done) begin
          pending_next = 1'b0;
          if (sq_last) begin
            if (!eps_neg && (sumsq_new[65:2] == 64'd0)) begin
              flags_next = raise_code(error_flags, CODE_ZERO);
              state_next = ST_DONE;
            end else begin
              state_next = ST_ROOT;
            end
          end
        end
      end
      ST_ROOT: begin
        sqrt_start   = !pending;
        pending_next = 1'b1;
        if (sqrt_done) begin
          pending_next = 1'b0;
          if (!eps_neg) begin
            state_next = ST_POT;
          end else if (shifted_r[32]) begin
            flags_next = raise_code(error_flags, CODE_PN);
            state_next = ST_DONE;
          end else if (shifted_r == 33'd0) begin
            flags_next = raise_code(error_flags, CODE_ZERO);
            state_next = ST_DONE;
          end else begin
            state_next = ST_RSQ;
          end
        end
      end
      ST_RSQ: begin
        mul_start    = !pending;
        pending_next = 1'b1;
        if (mul_done) begin
          pending_next = 1'b0;
          state_next   = ST_POT;
        end
      end
      ST_POT, ST_ADIV: begin
        div_start    = !pending;
        pending_next = 1'b1;
        if (div_done) begin
          pending_next = 1'b0;
          if (term_clip) begin
            flags_next = raise_code(flags_next, CODE_SAT);
          end
          if (acc_sat) begin
            flags_next = raise_code(flags_next, CODE_SAT);
          end
          if (state == ST_POT || idx != 2'd2) begin
            state_next = ST_AMUL;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_AMUL: begin
        mul_start    = !pending;
        pending_next = 1'b1;
        if (mul_done) begin
          pending_next = 1'b0;
          state_next   = ST_ADIV;
        end
      end
      ST_DONE: begin
        if (!last_q) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          flags_next = CODE_OK;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pending <= 1'b0;
    end else begin
      state   <= state_next;
      pending <= pending_next;
    end
  end

  // control state: softening, sums, status, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      softening     <= 32'sd3277;
      potential_sum <= '0;
      for (int i = 0; i < 3; i++) begin
        accel_sum[i] <= '0;
      end
      error_flags   <= CODE_OK;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (softening_wr_en) begin
        softening <= softening_wr_data;
      end
      error_flags <= flags_next;
      if (div_done && state == ST_POT) begin
        potential_sum <= acc_res;
      end
      if (div_done && state == ST_ADIV) begin
        accel_sum[idx] <= acc_res;
      end
      if (emit) begin
        potential_sum <= '0;
        for (int i = 0; i < 3; i++) begin
          accel_sum[i] <= '0;
        end
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // item payload, intermediate results and output data
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        mag[i] <= d_in[i][32] ? 32'(-d_in[i]) : d_in[i][31:0];
        neg[i] <= d_in[i][32];
      end
      mass   <= s_axis_tdata[223:192];
      last_q <= s_axis_tlast;
      idx    <= 2'd0;
      sumsq  <= '0;
    end
    case (state)
      ST_SQ: begin
        if (mul_done) begin
          sumsq <= sumsq_new;
          r2    <= sumsq_new[65:2];
          idx   <= sq_last ? 2'd0 : idx + 2'd1;
        end
      end
      ST_ROOT: begin
        if (sqrt_done) begin
          r <= eps_neg ? shifted_r[31:0] : sqrt_root;
        end
      end
      ST_RSQ: begin
        if (mul_done) begin
          r2 <= mul_p[63:0];
        end
      end
      ST_POT: begin
        if (div_done) begin
          p   <= div_q;
          idx <= 2'd0;
        end
      end
      ST_AMUL: begin
        if (mul_done) begin
          num_a <= {mul_p[86:0], 14'd0};
        end
      end
      ST_ADIV: begin
        if (div_done && idx != 2'd2) begin
          idx <= idx + 2'd1;
        end
      end
      default: ;
    endcase
    if (emit) begin
      m_axis_tdata[63:0]    <= 64'(potential_sum);
      m_axis_tdata[127:64]  <= 64'(accel_sum[0]);
      m_axis_tdata[191:128] <= 64'(accel_sum[1]);
      m_axis_tdata[255:192] <= 64'(accel_sum[2]);
      m_axis_tuser          <= error_flags;
    end
  end

  a_one_launch: assert property (@(posedge clk) disable iff (rst)
    $onehot0({mul_start, div_start, sqrt_start}))
    else $error("more than one arithmetic unit launched at once");

  a_mul_owner: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_SQ || state == ST_RSQ || state == ST_AMUL))
    else $error("multiplier result arrived outside a multiply state");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_POT || state == ST_ADIV))
    else $error("divider result arrived outside a divide state");

  a_clear_on_emit: assert property (@(posedge clk) disable iff (rst)
    emit |=> (potential_sum == '0 && error_flags == CODE_OK && m_axis_tvalid))
    else $error("sums or status not cleared after a result transfer");

endmodule

@@ dv/tb_softened_gravity_accumulator_unit.sv @@
// Self-checking testbench for the gravity accumulator: directed and random stream traffic vs. a predictor.
module tb_softened_gravity_accumulator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import sga_pkg::*;

  typedef struct packed {
    logic [31:0] mass;
    logic signed [31:0] sz, sy, sx, tz, ty, tx;
    logic is_self;
    logic last;
  } body_t;

  typedef struct {
    logic [63:0] pot, ax, ay, az;
    logic [1:0]  status;
  } sums_t;

  localparam longint SUM_MAX = 64'sh7fffffffffffffff;

  logic clk = 0, rst = 1;
  logic softening_wr_en = 0;
  logic [31:0] softening_wr_data = '0;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [223:0] s_axis_tdata = '0;
  logic s_axis_tuser = 0, s_axis_tlast = 0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [255:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  softened_gravity_accumulator_unit dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  body_t pending_bodies[$];
  sums_t expected_sums[$];
  int fail_count = 0;
  longint unsigned cycle_count = 0;

  // predictor state
  logic signed [31:0] eps_model = 32'sd3277;
  logic signed [63:0] pot_acc, ax_acc, ay_acc, az_acc;
  logic [1:0] flags_acc;

  function automatic void raise_flag(logic [1:0] code);
    if (code > flags_acc) flags_acc = code;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else res >>= 1;
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [63:0] clip_term(logic [127:0] mag, logic neg);
    logic [63:0] m;
    if (mag > 128'(SUM_MAX)) begin
      m = SUM_MAX;
      raise_flag(CODE_SAT);
    end else m = mag[63:0];
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] sat_sum(logic signed [63:0] acc, logic signed [63:0] t);
    logic signed [64:0] s;
    s = 65'(acc) + 65'(t);
    if (s > 65'(SUM_MAX)) begin
      raise_flag(CODE_SAT);
      return SUM_MAX;
    end
    if (s < -65'(SUM_MAX) - 1) begin
      raise_flag(CODE_SAT);
      return -SUM_MAX - 1;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] accel_term(logic signed [32:0] d, logic [63:0] p,
                                                     logic [63:0] r2);
    logic [32:0] ad;
    logic [127:0] q;
    ad = d < 0 ? -d : d;
    q = ((128'(p) * 128'(ad)) << 14) / 128'(r2);
    return clip_term(q, d < 0);
  endfunction

  function automatic void accumulate_body(body_t b);
    logic signed [32:0] dx, dy, dz;
    logic [65:0] qsum;
    logic [63:0] r, r2, p, half;
    logic signed [64:0] dr;
    dx = 33'(b.sx) - 33'(b.tx);
    dy = 33'(b.sy) - 33'(b.ty);
    dz = 33'(b.sz) - 33'(b.tz);
    qsum = 66'(dx * dx) + 66'(dy * dy) + 66'(dz * dz);
    if (eps_model >= 0) begin
      r2 = 64'((qsum + 66'(eps_model * eps_model)) >> 2);
      if (r2 == 0) begin
        raise_flag(CODE_ZERO);
        return;
      end
      r = int_sqrt(r2);
    end else begin
      half = (64'(-65'(eps_model)) + 1) >> 1;
      dr = 65'(int_sqrt(64'(qsum >> 2))) - 65'(half);
      if (dr < 0) begin
        raise_flag(CODE_PN);
        return;
      end
      if (dr == 0) begin
        raise_flag(CODE_ZERO);
        return;
      end
      r = dr[63:0];
      r2 = r * r;
    end
    p = (64'(b.mass) << 23) / r;
    pot_acc = sat_sum(pot_acc, clip_term(128'(p), 1'b1));
    ax_acc = sat_sum(ax_acc, accel_term(dx, p, r2));
    ay_acc = sat_sum(ay_acc, accel_term(dy, p, r2));
    az_acc = sat_sum(az_acc, accel_term(dz, p, r2));
  endfunction

  function automatic void predict_body(body_t b);
    sums_t s;
    if (!b.is_self) accumulate_body(b);
    if (b.last) begin
      s.pot = pot_acc;
      s.ax = ax_acc;
      s.ay = ay_acc;
      s.az = az_acc;
      s.status = flags_acc;
      expected_sums.push_back(s);
      pot_acc = 0; ax_acc = 0; ay_acc = 0; az_acc = 0; flags_acc = CODE_OK;
    end
  endfunction

  function automatic logic [31:0] rand_coord(int sel);
    case (sel)
      0: return $urandom;
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      default: return $urandom_range(0, 32'h60000) - 32'h30000;
    endcase
  endfunction

  function automatic body_t rand_body(logic signed [31:0] tx, logic signed [31:0] ty,
                                      logic signed [31:0] tz, logic lst);
    body_t b;
    int wide;
    wide = ($urandom_range(0, 9) == 0);
    b.tx = tx; b.ty = ty; b.tz = tz;
    b.sx = wide ? rand_coord($urandom_range(0, 2)) : tx + rand_coord(3);
    b.sy = wide ? rand_coord($urandom_range(0, 2)) : ty + rand_coord(3);
    b.sz = wide ? rand_coord($urandom_range(0, 2)) : tz + rand_coord(3);
    if ($urandom_range(0, 15) == 0) begin
      b.sx = tx; b.sy = ty; b.sz = tz;
    end
    case ($urandom_range(0, 5))
      0: b.mass = $urandom;
      1: b.mass = 32'hffffffff;
      2: b.mass = 0;
      default: b.mass = $urandom_range(0, 32'h04000000);
    endcase
    b.is_self = ($urandom_range(0, 9) == 0);
    b.last = lst;
    return b;
  endfunction

  // sender: bursts with random gaps
  int burst_left = 0, gap_left = 0;
  logic hold_off = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) void'(pending_bodies.pop_front());
      if (s_axis_tvalid && !(s_axis_tready)) begin
        // hold until taken
      end else if (gap_left > 0 || hold_off || pending_bodies.size() == 0) begin
        s_axis_tvalid <= 0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        s_axis_tvalid <= 1;
        {s_axis_tdata[223:192], s_axis_tdata[191:160], s_axis_tdata[159:128],
         s_axis_tdata[127:96], s_axis_tdata[95:64], s_axis_tdata[63:32],
         s_axis_tdata[31:0]} <= {pending_bodies[0].mass, pending_bodies[0].sz,
         pending_bodies[0].sy, pending_bodies[0].sx, pending_bodies[0].tz,
         pending_bodies[0].ty, pending_bodies[0].tx};
        s_axis_tuser <= pending_bodies[0].is_self;
        s_axis_tlast <= pending_bodies[0].last;
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 8);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end
      end
    end
  end

  // receiver: stall pattern with quiet stretches
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= (stall_phase + 1) % 200;
    if (stall_phase < 60) m_axis_tready <= 1;
    else if (stall_phase < 120) m_axis_tready <= (stall_phase % 3 != 0);
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin
    sums_t e;
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        predict_body('{s_axis_tdata[223:192], s_axis_tdata[191:160], s_axis_tdata[159:128],
                       s_axis_tdata[127:96], s_axis_tdata[95:64], s_axis_tdata[63:32],
                       s_axis_tdata[31:0], s_axis_tuser, s_axis_tlast});
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_sums.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count++;
        end else begin
          e = expected_sums.pop_front();
          if (m_axis_tdata[63:0] !== e.pot) begin
            $error("potential: expected %h, got %h", e.pot, m_axis_tdata[63:0]);
            fail_count++;
          end
          if (m_axis_tdata[127:64] !== e.ax) begin
            $error("accel_x: expected %h, got %h", e.ax, m_axis_tdata[127:64]);
            fail_count++;
          end
          if (m_axis_tdata[191:128] !== e.ay) begin
            $error("accel_y: expected %h, got %h", e.ay, m_axis_tdata[191:128]);
            fail_count++;
          end
          if (m_axis_tdata[255:192] !== e.az) begin
            $error("accel_z: expected %h, got %h", e.az, m_axis_tdata[255:192]);
            fail_count++;
          end
          if (m_axis_tuser !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, m_axis_tuser);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > 64'd3000000) begin
      $display("softened_gravity_accumulator_unit: mismatch");
      $finish;
    end
  end

  task automatic drain_all();
    while (pending_bodies.size() != 0 || s_axis_tvalid || expected_sums.size() != 0)
      @(posedge clk);
    repeat (800) @(posedge clk);
  endtask

  task automatic write_softening(logic [31:0] v);
    softening_wr_en <= 1;
    softening_wr_data <= v;
    @(posedge clk);
    softening_wr_en <= 0;
    eps_model = v;
    @(posedge clk);
  endtask

  task automatic queue_target_run(int n);
    logic signed [31:0] tx, ty, tz;
    tx = rand_coord($urandom_range(0, 9) == 0 ? 0 : 3);
    ty = rand_coord(3);
    tz = rand_coord(3);
    for (int i = 0; i < n; i++)
      pending_bodies.push_back(rand_body(tx, ty, tz, i == n - 1));
  endtask

  initial begin
    logic [31:0] eps_list[6];
    pot_acc = 0; ax_acc = 0; ay_acc = 0; az_acc = 0; flags_acc = CODE_OK;
    eps_list = '{32'h00000000, 32'h80000000, 32'h7fffffff, 32'hfffe0000, 32'h00000100,
                 32'hffffffff};
    repeat (4) @(posedge clk);
    rst <= 0;

    // directed: reset softening, extremes, self, coincident, last alone
    pending_bodies.push_back('{32'h01000000, 32'sd65536, 0, 0, 0, 0, 0, 1'b0, 1'b0});
    pending_bodies.push_back('{32'hffffffff, 32'h80000000, 32'h80000000, 32'h80000000,
                               32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, 1'b0});
    pending_bodies.push_back('{32'hffffffff, 0, 0, 32'sd1, 0, 0, 0, 1'b0, 1'b0});
    pending_bodies.push_back('{32'h12345678, 5, 6, 7, 5, 6, 7, 1'b0, 1'b0});
    pending_bodies.push_back('{32'h0, -32'sd3, 32'sd9, 32'sd1, 0, 0, 0, 1'b0, 1'b1});
    pending_bodies.push_back('{32'hffffffff, 1, 2, 3, 4, 5, 6, 1'b1, 1'b1});
    drain_all();

    write_softening(32'h0);
    pending_bodies.push_back('{32'h01000000, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1});
    pending_bodies.push_back('{32'h01000000, 0, 0, -32'sd65536, 0, 0, 0, 1'b0, 1'b1});
    drain_all();

    write_softening(32'hfffe0000);
    pending_bodies.push_back('{32'h01000000, 0, 0, 32'sd65536, 0, 0, 0, 1'b0, 1'b0});
    pending_bodies.push_back('{32'h01000000, 0, 0, 32'sd131072, 0, 0, 0, 1'b0, 1'b0});
    pending_bodies.push_back('{32'h01000000, 0, -32'sd1000000, 0, 0, 0, 0, 1'b0, 1'b1});
    drain_all();

    for (int ph = 0; ph < 6; ph++) begin
      write_softening(ph == 5 ? 32'(3277) : eps_list[ph]);
      for (int k = 0; k < 12; k++) begin
        queue_target_run($urandom_range(1, 10));
        if (k == 6) begin
          // pause feed until all results are back
          hold_off = 1;
          while (pending_bodies.size() != 0 || s_axis_tvalid) begin
            hold_off = 0;
            @(posedge clk);
          end
          hold_off = 1;
          while (expected_sums.size() != 0) @(posedge clk);
          hold_off = 0;
        end
      end
      drain_all();
    end

    drain_all();
    if (fail_count == 0) $display("softened_gravity_accumulator_unit: match");
    else $display("softened_gravity_accumulator_unit: mismatch");
    $finish;
  end
endmodule
